FILE: hw/rtl/iwle_pkg.sv
// Shared constants, command/status codes and control structs for the word list engine.
`default_nettype none

package iwle_pkg;

  localparam int CAPACITY    = 256;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 3;
  localparam int POS_W       = 8;
  localparam int WORD_W      = 32;
  localparam int ST_W        = 3;
  localparam int COUNT_OUT_W = 9;
  // width for comparing a request position against the count
  localparam int PC_W        = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_GET    = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {RD_POS, RD_NEXT, RD_ZERO} rd_sel_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_POS, IDX_INC} idx_op_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;

  typedef struct packed {
    logic            capture;
    logic            res_clear;
    logic            set_status;
    logic [ST_W-1:0] status_code;
    logic            take_word;
    logic            take_where;
    logic            wr_en;
    logic            wr_shift;
    rd_sel_t         rd_sel;
    idx_op_t         idx_op;
    cnt_op_t         cnt_op;
    logic            out_load;
  } iwle_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            pos_ok;
    logic            match;
    logic            idx_last;
    logic            out_free;
  } iwle_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iwle_dpath.sv
// Datapath: request registers, word memory, count, walk index, result and output registers.
`default_nettype none

module iwle_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [iwle_pkg::OP_W-1:0]      op,
  input  wire logic [iwle_pkg::POS_W-1:0]     position,
  input  wire logic [iwle_pkg::WORD_W-1:0]    word_in,
  input  wire logic                           out_stall,
  input  wire iwle_pkg::iwle_cmd_t            cmd,
  output iwle_pkg::iwle_stat_t                stat,
  output logic                                out_valid,
  output logic [iwle_pkg::WORD_W-1:0]         word_out,
  output logic [iwle_pkg::POS_W-1:0]          found_position,
  output logic [iwle_pkg::ST_W-1:0]           status,
  output logic [iwle_pkg::COUNT_OUT_W-1:0]    count_out
);
  import iwle_pkg::*;

  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] key_r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [CNT_W-1:0]  idx_plus;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;

  logic [WORD_W-1:0] res_word;
  logic [POS_W-1:0]  res_where;
  logic [ST_W-1:0]   res_status;

  assign idx_plus = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_POS:  rd_addr = IDX_W'(pos_r);
      RD_NEXT: rd_addr = idx_plus[IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // append writes at the tail, shifting writes one slot below the word just read
  assign wr_addr = cmd.wr_shift ? (idx - IDX_W'(1)) : count[IDX_W-1:0];
  assign wr_data = cmd.wr_shift ? rd_data : key_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op;
      pos_r <= position;
      key_r <= word_in;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_next = count + CNT_W'(1);
      CNT_DEC: count_next = count - CNT_W'(1);
      CNT_CLR: count_next = '0;
      default: count_next = count;
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO: idx_next = '0;
      IDX_POS:  idx_next = IDX_W'(pos_r);
      IDX_INC:  idx_next = idx_plus[IDX_W-1:0];
      default:  idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_word   <= '0;
      res_where  <= '0;
      res_status <= ST_OK;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.take_word) begin
        res_word <= rd_data;
      end
      if (cmd.take_where) begin
        res_where <= POS_W'(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      word_out       <= res_word;
      found_position <= res_where;
      status         <= res_status;
      count_out      <= COUNT_OUT_W'(count);
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.full     = (count >= CNT_W'(CAPACITY));
    stat.empty    = (count == '0);
    stat.pos_ok   = (PC_W'(pos_r) < PC_W'(count));
    stat.match    = (rd_data == key_r);
    stat.idx_last = (idx_plus >= count);
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/iwle_ctrl.sv
// Controller: request sequencing state machine driving the datapath commands.
`default_nettype none

module iwle_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire iwle_pkg::iwle_stat_t stat,
  output iwle_pkg::iwle_cmd_t       cmd
);
  import iwle_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_GET_RD   = 7'b0000100,
    S_RM_TAKE  = 7'b0001000,
    S_SHIFT    = 7'b0010000,
    S_SCAN     = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          cmd.res_clear = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.cnt_op = CNT_INC;
            end
          end
          OP_GET: begin
            if (stat.pos_ok) begin
              cmd.rd_sel = RD_POS;
              state_next = S_GET_RD;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          OP_FIND: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
            end else begin
              cmd.rd_sel = RD_ZERO;
              cmd.idx_op = IDX_ZERO;
              state_next = S_SCAN;
            end
          end
          OP_REMOVE: begin
            if (stat.pos_ok) begin
              cmd.rd_sel = RD_POS;
              cmd.idx_op = IDX_POS;
              state_next = S_RM_TAKE;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end
      S_GET_RD: begin
        cmd.take_word = 1'b1;
        state_next    = S_FINISH;
      end
      S_RM_TAKE: begin
        cmd.take_word = 1'b1;
        if (stat.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end else begin
          cmd.rd_sel = RD_NEXT;
          cmd.idx_op = IDX_INC;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        if (stat.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end else begin
          cmd.rd_sel = RD_NEXT;
          cmd.idx_op = IDX_INC;
        end
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.take_where = 1'b1;
          state_next     = S_FINISH;
        end else if (stat.idx_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOTFOUND;
          state_next      = S_FINISH;
        end else begin
          cmd.rd_sel = RD_NEXT;
          cmd.idx_op = IDX_INC;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_word_list_engine.sv
// Top level of the indexed word list engine: controller plus datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   request  | in_valid / in_stall  | op, position, word_in
//   result   | out_valid / out_stall| word_out, found_position, status, count_out
//
// One request is worked at a time; in_stall is high from acceptance until
// its result is loaded into the output register.
// Append, clear and unused ops go from DISPATCH to FINISH; get adds GET_RD.
// Find scans from index 0 until a match or the last word. Remove takes the
// word in RM_TAKE, then SHIFT moves each later word down; the one-read,
// one-write word memory moves one word per cycle, setting find and remove time.
// Reset clears the count and control only; stored words need no clearing.
// A stalled result holds in the output register; the next request can be
// accepted meanwhile and waits in FINISH for the register to free up.
`default_nettype none

module indexed_word_list_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [iwle_pkg::OP_W-1:0]      op,
  input  wire logic [iwle_pkg::POS_W-1:0]     position,
  input  wire logic [iwle_pkg::WORD_W-1:0]    word_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [iwle_pkg::WORD_W-1:0]         word_out,
  output logic [iwle_pkg::POS_W-1:0]          found_position,
  output logic [iwle_pkg::ST_W-1:0]           status,
  output logic [iwle_pkg::COUNT_OUT_W-1:0]    count_out
);
  import iwle_pkg::*;

  iwle_cmd_t  cmd;   // controller -> datapath
  iwle_stat_t stat;  // datapath -> controller

  iwle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  iwle_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .position       (position),
    .word_in        (word_in),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .word_out       (word_out),
    .found_position (found_position),
    .status         (status),
    .count_out      (count_out)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/iwle_checker.sv
// Port-level checker for the word list engine, bound to the top level.
`default_nettype none

module iwle_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [iwle_pkg::WORD_W-1:0]    word_out,
  input wire logic [iwle_pkg::POS_W-1:0]     found_position,
  input wire logic [iwle_pkg::ST_W-1:0]      status,
  input wire logic [iwle_pkg::COUNT_OUT_W-1:0] count_out
);
  import iwle_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_out) && $stable(status)
      && $stable(found_position) && $stable(count_out))
    else $error("result changed while stalled");

  // one request at a time: acceptance closes the request side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request side open right after acceptance");

  // failed requests carry no word and no position
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (word_out == '0) && (found_position == '0))
    else $error("failed request returned data");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_RANGE) || (status == ST_EMPTY)
      || (status == ST_FULL) || (status == ST_NOTFOUND))
    else $error("undefined status code");

  // a result shows up only after some request was accepted earlier
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

endmodule

bind indexed_word_list_engine iwle_checker u_iwle_checker (.*);

`default_nettype wire
